### sv/pdto_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdto_pkg
// Shared widths, codes, register defaults and types of the pixel dead-time
// and occupancy filter.
// ---------------------------------------------------------------------------
package pdto_pkg;

   // Beat field widths
   localparam int ACTION_W = 1;
   localparam int PIXEL_W  = 12;
   localparam int GROUP_W  = 6;
   localparam int TIME_W   = 40;
   localparam int STATUS_W = 3;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DEAD_W     = 16;
   localparam int COUNT_W    = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_TIME  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HITS   = 2'd2;

   // 30 ns in 1/16 ns ticks
   localparam logic [DEAD_W-1:0]  DEAD_TIME_RST = 16'd480;
   localparam logic [COUNT_W-1:0] MAX_HITS_RST  = 13'd65;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 13'h1FFF;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_HIT   = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_DRAIN = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_NEW    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MERGED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LOST   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OUT    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DONE   = 3'd4;

   typedef struct packed {
      logic lost;
      logic is_new;
   } hit_verdict_type;

endpackage

### sv/pdto_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdto_req_if / pdto_rsp_if
// Valid/ready channels carrying hit and drain requests and their responses.
// ---------------------------------------------------------------------------
interface pdto_req_if;
   logic                              valid;
   logic                              ready;
   logic [pdto_pkg::ACTION_W-1:0]     action;
   logic [pdto_pkg::PIXEL_W-1:0]      pixel;
   logic [pdto_pkg::GROUP_W-1:0]      sensor_group;
   logic [pdto_pkg::TIME_W-1:0]       hit_time;

   modport source (output valid, action, pixel, sensor_group, hit_time, input ready);
   modport sink   (input valid, action, pixel, sensor_group, hit_time, output ready);
endinterface

interface pdto_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pdto_pkg::STATUS_W-1:0]     status;
   logic [pdto_pkg::PIXEL_W-1:0]      out_pixel;
   logic [pdto_pkg::TIME_W-1:0]       out_time;

   modport source (output valid, status, out_pixel, out_time, input ready);
   modport sink   (input valid, status, out_pixel, out_time, output ready);
endinterface

### sv/pixel_dead_time_occupancy_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pixel_dead_time_occupancy_filter
// Per-pixel dead-time filter and event digi builder with group occupancy cut.
// ---------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  req_ch   in   valid/ready         action, pixel, sensor_group, hit_time
//  rsp_ch   out  valid/ready         status, out_pixel, out_time
//  csr_*    in   csr_we              csr_index, csr_wdata
//
// A hit is accepted with its pixel/group RAM read, then written back in S_HIT.
// A drain scans pixels in order from the cursor and fetches the group count
// of each digi found; the single pixel RAM read port sets the pace.
// Drain done and reset both start a sweep over max(PIXELS, GROUPS) entries
// that clears event state; no request is taken during the sweep.
// A stalled response holds the block in its result state; one further
// request may be accepted while a response waits.
// ---------------------------------------------------------------------------
module pixel_dead_time_occupancy_filter #(
   parameter int PIXELS    = 4096,
   parameter int GROUPS    = 64,
   parameter int TIME_BITS = 40
) (
   input  logic                              clock,
   input  logic                              reset,
   pdto_req_if.sink                          req_ch,
   pdto_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [pdto_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pdto_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int PW      = $clog2(PIXELS);
   localparam int GW      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int TW      = TIME_BITS;
   localparam int CW      = PW + 1;
   localparam int PXW     = pdto_pkg::PIXEL_W;
   localparam int GRW     = pdto_pkg::GROUP_W;
   localparam int OTW     = pdto_pkg::TIME_W;
   localparam int NW      = pdto_pkg::COUNT_W;
   localparam int SWEEP_N = (PIXELS > GROUPS) ? PIXELS : GROUPS;
   localparam int SW      = $clog2(SWEEP_N + 1);

   // index reduction by reciprocal multiply, exact for the field width
   localparam int PIX_SH  = PXW + PW;
   localparam logic [31:0] PIX_M =
      32'(((64'd1 << PIX_SH) + 64'(PIXELS) - 64'd1) / 64'(PIXELS));
   localparam int GRP_SH  = GRW + GW;
   localparam logic [31:0] GRP_M =
      32'(((64'd1 << GRP_SH) + 64'(GROUPS) - 64'd1) / 64'(GROUPS));

   localparam logic [CW-1:0] CUR_END   = CW'(PIXELS);
   localparam logic [SW-1:0] SWEEP_PIX = SW'(PIXELS);
   localparam logic [SW-1:0] SWEEP_GRP = SW'(GROUPS);
   localparam logic [SW-1:0] SWEEP_END = SW'(SWEEP_N);

   typedef struct packed {
      logic          fired;
      logic [TW-1:0] last;
      logic          present;
      logic [TW-1:0] evt;
      logic [GW-1:0] evg;
   } pix_word_type;

   typedef enum logic [5:0] {
      S_CLEAR    = 6'b000001,
      S_IDLE     = 6'b000010,
      S_HIT      = 6'b000100,
      S_SCAN_CHK = 6'b001000,
      S_SCAN_GRP = 6'b010000,
      S_FIN      = 6'b100000
   } state_type;

   // Configuration registers
   logic                            event_mode_ff;
   logic [pdto_pkg::DEAD_W-1:0]     dead_time_ff;
   logic [NW-1:0]                   max_hits_ff;

   // Control
   state_type                       state_ff, state_in;
   logic                            clr_full_ff, clr_full_in;
   logic [SW-1:0]                   sweep_ff, sweep_in;
   logic [CW-1:0]                   cursor_ff, cursor_in;
   logic [PW-1:0]                   cur_pix_ff, cur_pix_in;
   logic [GW-1:0]                   cur_grp_ff, cur_grp_in;
   logic [TW-1:0]                   cur_time_ff, cur_time_in;

   // Response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pdto_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [PXW-1:0]                  out_pixel_ff, out_pixel_in;
   logic [OTW-1:0]                  out_time_ff, out_time_in;
   logic                            emit;
   logic                            out_free;

   // RAM ports
   logic                            pix_we, pix_re;
   logic [PW-1:0]                   pix_waddr, pix_raddr;
   pix_word_type                    pix_wdata, pix_rd, pix_clr, pix_hit;
   logic                            grp_we, grp_re;
   logic [GW-1:0]                   grp_waddr, grp_raddr;
   logic [NW-1:0]                   grp_wdata, grp_rd, count_next;

   // Request decode
   logic [31:0]                     pix_q, pix_r, grp_q, grp_r;
   logic [PW-1:0]                   p_red;
   logic [GW-1:0]                   g_red;
   pdto_pkg::hit_verdict_type       verdict;

   assign pix_q = (32'(req_ch.pixel) * PIX_M) >> PIX_SH;
   assign pix_r = 32'(req_ch.pixel) - pix_q * 32'(PIXELS);
   assign p_red = PW'(pix_r);
   assign grp_q = (32'(req_ch.sensor_group) * GRP_M) >> GRP_SH;
   assign grp_r = 32'(req_ch.sensor_group) - grp_q * 32'(GROUPS);
   assign g_red = GW'(grp_r);

   pdto_ram #(
      .WIDTH ($bits(pix_word_type)),
      .DEPTH (PIXELS)
   ) u_pix_ram (
      .clock (clock),
      .we    (pix_we),
      .waddr (pix_waddr),
      .wdata (pix_wdata),
      .re    (pix_re),
      .raddr (pix_raddr),
      .rdata (pix_rd)
   );

   pdto_ram #(
      .WIDTH (NW),
      .DEPTH (GROUPS)
   ) u_grp_ram (
      .clock (clock),
      .we    (grp_we),
      .waddr (grp_waddr),
      .wdata (grp_wdata),
      .re    (grp_re),
      .raddr (grp_raddr),
      .rdata (grp_rd)
   );

   pdto_hit_unit #(
      .TIME_BITS (TW)
   ) u_hit_unit (
      .event_mode (event_mode_ff),
      .dead_time  (dead_time_ff),
      .fired      (pix_rd.fired),
      .last_time  (pix_rd.last),
      .present    (pix_rd.present),
      .hit_time   (cur_time_ff),
      .verdict    (verdict)
   );

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign count_next = (grp_rd == pdto_pkg::COUNT_MAX) ? grp_rd : grp_rd + NW'(1);

   always_comb begin
      pix_clr         = pix_rd;
      pix_clr.present = 1'b0;

      pix_hit         = pix_rd;
      pix_hit.fired   = 1'b1;
      pix_hit.last    = cur_time_ff;
      if (verdict.is_new) begin
         pix_hit.present = 1'b1;
         pix_hit.evt     = cur_time_ff;
         pix_hit.evg     = cur_grp_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_full_in  = clr_full_ff;
      sweep_in     = sweep_ff;
      cursor_in    = cursor_ff;
      cur_pix_in   = cur_pix_ff;
      cur_grp_in   = cur_grp_ff;
      cur_time_in  = cur_time_ff;

      pix_re       = 1'b0;
      pix_raddr    = cursor_ff[PW-1:0];
      pix_we       = 1'b0;
      pix_waddr    = cur_pix_ff;
      pix_wdata    = pix_hit;
      grp_re       = 1'b0;
      grp_raddr    = cur_grp_ff;
      grp_we       = 1'b0;
      grp_waddr    = cur_grp_ff;
      grp_wdata    = count_next;

      emit         = 1'b0;
      status_in    = pdto_pkg::ST_NEW;
      out_pixel_in = PXW'(cur_pix_ff);
      out_time_in  = '0;

      req_ch.ready = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // read entry i while writing back entry i-1
            if (sweep_ff < SWEEP_PIX) begin
               pix_re    = 1'b1;
               pix_raddr = PW'(sweep_ff);
            end
            if ((sweep_ff != '0) && (sweep_ff <= SWEEP_PIX)) begin
               pix_we    = 1'b1;
               pix_waddr = PW'(sweep_ff - SW'(1));
               pix_wdata = clr_full_ff ? '0 : pix_clr;
            end
            if (sweep_ff < SWEEP_GRP) begin
               grp_we    = 1'b1;
               grp_waddr = GW'(sweep_ff);
               grp_wdata = '0;
            end
            if (sweep_ff == SWEEP_END) begin
               state_in    = S_IDLE;
               clr_full_in = 1'b0;
               sweep_in    = '0;
            end else begin
               sweep_in = sweep_ff + SW'(1);
            end
         end

         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (req_ch.action == pdto_pkg::ACT_DRAIN) begin
                  if (cursor_ff == CUR_END) begin
                     state_in = S_FIN;
                  end else begin
                     pix_re     = 1'b1;
                     pix_raddr  = cursor_ff[PW-1:0];
                     cur_pix_in = cursor_ff[PW-1:0];
                     cursor_in  = cursor_ff + CW'(1);
                     state_in   = S_SCAN_CHK;
                  end
               end else begin
                  cur_pix_in  = p_red;
                  cur_grp_in  = g_red;
                  cur_time_in = TW'(req_ch.hit_time);
                  pix_re      = 1'b1;
                  pix_raddr   = p_red;
                  grp_re      = 1'b1;
                  grp_raddr   = g_red;
                  state_in    = S_HIT;
               end
            end
         end

         S_HIT: begin
            if (out_free) begin
               pix_we = 1'b1;
               emit   = 1'b1;
               if (verdict.lost) begin
                  status_in = pdto_pkg::ST_LOST;
               end else if (verdict.is_new) begin
                  grp_we      = 1'b1;
                  status_in   = pdto_pkg::ST_NEW;
                  out_time_in = OTW'(cur_time_ff);
               end else begin
                  status_in   = pdto_pkg::ST_MERGED;
                  out_time_in = OTW'(pix_rd.evt);
               end
               state_in = S_IDLE;
            end
         end

         S_SCAN_CHK: begin
            if (pix_rd.present) begin
               grp_re    = 1'b1;
               grp_raddr = pix_rd.evg;
               state_in  = S_SCAN_GRP;
            end else if (cursor_ff == CUR_END) begin
               state_in = S_FIN;
            end else begin
               pix_re     = 1'b1;
               pix_raddr  = cursor_ff[PW-1:0];
               cur_pix_in = cursor_ff[PW-1:0];
               cursor_in  = cursor_ff + CW'(1);
            end
         end

         S_SCAN_GRP: begin
            if (grp_rd <= max_hits_ff) begin
               if (out_free) begin
                  emit        = 1'b1;
                  status_in   = pdto_pkg::ST_OUT;
                  out_time_in = OTW'(pix_rd.evt);
                  state_in    = S_IDLE;
               end
            end else if (cursor_ff == CUR_END) begin
               state_in = S_FIN;
            end else begin
               // skip a digi of an over-occupied group
               pix_re     = 1'b1;
               pix_raddr  = cursor_ff[PW-1:0];
               cur_pix_in = cursor_ff[PW-1:0];
               cursor_in  = cursor_ff + CW'(1);
               state_in   = S_SCAN_CHK;
            end
         end

         S_FIN: begin
            if (out_free) begin
               emit         = 1'b1;
               status_in    = pdto_pkg::ST_DONE;
               out_pixel_in = '0;
               cursor_in    = '0;
               sweep_in     = '0;
               clr_full_in  = 1'b0;
               state_in     = S_CLEAR;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_full_ff   <= 1'b1;
         sweep_ff      <= '0;
         cursor_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         event_mode_ff <= 1'b0;
         dead_time_ff  <= pdto_pkg::DEAD_TIME_RST;
         max_hits_ff   <= pdto_pkg::MAX_HITS_RST;
      end else begin
         state_ff     <= state_in;
         clr_full_ff  <= clr_full_in;
         sweep_ff     <= sweep_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               pdto_pkg::CSR_EVENT_MODE: event_mode_ff <= csr_wdata[0];
               pdto_pkg::CSR_DEAD_TIME:  dead_time_ff  <= csr_wdata;
               pdto_pkg::CSR_MAX_HITS:   max_hits_ff   <= csr_wdata[NW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_pix_ff  <= cur_pix_in;
      cur_grp_ff  <= cur_grp_in;
      cur_time_ff <= cur_time_in;
      if (emit) begin
         status_ff    <= status_in;
         out_pixel_ff <= out_pixel_in;
         out_time_ff  <= out_time_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.out_pixel = out_pixel_ff;
   assign rsp_ch.out_time  = out_time_ff;

endmodule

### sv/pdto_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdto_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module pdto_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // hold read data until the next read
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/pdto_hit_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdto_hit_unit
// Dead-time check of one hit against the pixel's last firing time.
// ---------------------------------------------------------------------------
module pdto_hit_unit #(
   parameter int TIME_BITS = 40
) (
   input  logic                          event_mode,
   input  logic [pdto_pkg::DEAD_W-1:0]   dead_time,
   input  logic                          fired,
   input  logic [TIME_BITS-1:0]          last_time,
   input  logic                          present,
   input  logic [TIME_BITS-1:0]          hit_time,
   output pdto_pkg::hit_verdict_type     verdict
);

   logic [TIME_BITS:0]   diff_fwd;
   logic [TIME_BITS-1:0] diff_abs;
   logic                 lost;

   // borrow out of the forward difference picks the reverse one
   assign diff_fwd = {1'b0, hit_time} - {1'b0, last_time};
   assign diff_abs = diff_fwd[TIME_BITS] ? (last_time - hit_time) : diff_fwd[TIME_BITS-1:0];

   assign lost = !event_mode && fired && (diff_abs < TIME_BITS'(dead_time));

   assign verdict.lost   = lost;
   assign verdict.is_new = !lost && !present;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel dead-time and occupancy filter. Directed
// beats probe both edges of the dead-time window, event mode, hits that land
// behind and ahead of a running drain, and the group occupancy cut. Random
// events then hammer small sets of hot pixels, drain them with hits mixed in,
// and rotate register settings and handshake idling. Each response is checked
// field by field against an in-bench model of the pixel and group tables.
// ---------------------------------------------------------------------------
module tb_top;
   import pdto_pkg::*;

   localparam int NUM_PIXELS     = 4096;
   localparam int NUM_GROUPS     = 64;
   localparam int TOTAL_BEATS    = 1000;
   localparam int WATCHDOG_LIMIT = 50000;
   localparam int MAX_PRINTS     = 40;
   localparam int HOT_MAX        = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [TIME_W-1:0] RST_WINDOW = TIME_W'(DEAD_TIME_RST);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PIXEL_W-1:0]  pixel;
      logic [TIME_W-1:0]   digi_time;
   } digi_response_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  rsp_ready_q = 1'b0;

   pdto_req_if req_ch();
   pdto_rsp_if rsp_ch();

   assign rsp_ch.ready = rsp_ready_q;

   pixel_dead_time_occupancy_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Filter state as the bench sees it
   bit                 cfg_event_mode = 1'b0;
   bit [DEAD_W-1:0]    cfg_dead_time  = DEAD_TIME_RST;
   bit [COUNT_W-1:0]   cfg_max_hits   = MAX_HITS_RST;
   bit [TIME_W-1:0]    fire_time     [NUM_PIXELS];
   bit                 has_fired     [NUM_PIXELS];
   bit                 digi_valid    [NUM_PIXELS];
   bit [TIME_W-1:0]    digi_time_tab [NUM_PIXELS];
   bit [GROUP_W-1:0]   digi_group    [NUM_PIXELS];
   bit [COUNT_W-1:0]   group_digis   [NUM_GROUPS];
   int                 scan_ptr = 0;

   digi_response_type  expected_responses[$];

   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   int                 errors         = 0;
   int                 beats_sent     = 0;
   int                 idle_cycles    = 0;

   logic [PIXEL_W-1:0] hot_pixels [HOT_MAX];
   logic [GROUP_W-1:0] hot_groups [3];
   int                 hot_count = 1;
   logic [TIME_W-1:0]  hit_clock = '0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic digi_response_type predict_response(input logic act,
         input logic [PIXEL_W-1:0] pix, input logic [GROUP_W-1:0] grp,
         input logic [TIME_W-1:0] ht);
      logic [TIME_W-1:0] gap;
      logic              lost;
      int                p;
      digi_response_type r;
      r = '0;
      if (act == ACT_DRAIN) begin
         while (scan_ptr < NUM_PIXELS) begin
            p = scan_ptr;
            scan_ptr++;
            if (digi_valid[p] && group_digis[digi_group[p]] <= cfg_max_hits) begin
               r.status    = ST_OUT;
               r.pixel     = PIXEL_W'(p);
               r.digi_time = digi_time_tab[p];
               return r;
            end
         end
         foreach (digi_valid[i]) digi_valid[i] = 1'b0;
         foreach (group_digis[i]) group_digis[i] = '0;
         scan_ptr = 0;
         r.status = ST_DONE;
         return r;
      end
      lost = 1'b0;
      if (!cfg_event_mode && has_fired[pix]) begin
         gap  = (ht >= fire_time[pix]) ? ht - fire_time[pix] : fire_time[pix] - ht;
         lost = gap < TIME_W'(cfg_dead_time);
      end
      r.pixel = pix;
      if (lost) begin
         r.status = ST_LOST;
      end else if (!digi_valid[pix]) begin
         digi_valid[pix]    = 1'b1;
         digi_time_tab[pix] = ht;
         digi_group[pix]    = grp;
         if (group_digis[grp] != COUNT_MAX) group_digis[grp]++;
         r.status    = ST_NEW;
         r.digi_time = ht;
      end else begin
         r.status    = ST_MERGED;
         r.digi_time = digi_time_tab[pix];
      end
      // every hit refreshes the window, lost or not
      fire_time[pix] = ht;
      has_fired[pix] = 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic send_beat(input logic act, input logic [PIXEL_W-1:0] pix,
         input logic [GROUP_W-1:0] grp, input logic [TIME_W-1:0] ht,
         output logic [STATUS_W-1:0] st);
      digi_response_type exp_r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.pixel        <= pix;
      req_ch.sensor_group <= grp;
      req_ch.hit_time     <= ht;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      exp_r = predict_response(act, pix, grp, ht);
      expected_responses.push_back(exp_r);
      beats_sent++;
      st = exp_r.status;
   endtask

   task automatic send_hit(input logic [PIXEL_W-1:0] pix, input logic [GROUP_W-1:0] grp,
         input logic [TIME_W-1:0] ht);
      logic [STATUS_W-1:0] st;
      send_beat(ACT_HIT, pix, grp, ht, st);
   endtask

   task automatic send_drain(output logic [STATUS_W-1:0] st);
      send_beat(ACT_DRAIN, PIXEL_W'($urandom), GROUP_W'($urandom),
                {8'($urandom), $urandom}, st);
   endtask

   // Hold off until every response is in, then leave a few spare cycles.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (expected_responses.size() != 0);
      repeat (4) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] val);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_EVENT_MODE: cfg_event_mode = val[0];
         CSR_DEAD_TIME:  cfg_dead_time  = val;
         CSR_MAX_HITS:   cfg_max_hits   = val[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_event_hit();
      logic [PIXEL_W-1:0] pix;
      logic [GROUP_W-1:0] grp;
      logic [TIME_W-1:0]  ht;
      int unsigned        span;
      span = (cfg_dead_time == 0) ? 64 : cfg_dead_time;
      if ($urandom_range(99) < 10) begin
         pix = PIXEL_W'($urandom);
         grp = GROUP_W'($urandom);
         ht  = {8'($urandom), $urandom};
      end else begin
         pix = hot_pixels[$urandom_range(hot_count - 1)];
         grp = hot_groups[$urandom_range(2)];
         if ($urandom_range(99) < 20) begin
            // step back in time to probe the early side of the window
            ht = hit_clock - TIME_W'($urandom_range(span));
         end else begin
            // spread so each hot pixel sees gaps around one dead time
            hit_clock = hit_clock + TIME_W'($urandom_range(2 * span / hot_count + 1));
            ht = hit_clock;
         end
      end
      send_hit(pix, grp, ht);
   endtask

   task automatic drain_event(input int hit_pct);
      logic [STATUS_W-1:0] st;
      do begin
         if (hit_pct != 0 && $urandom_range(99) < hit_pct) send_event_hit();
         send_drain(st);
      end while (st != ST_DONE);
   endtask

   task automatic run_event();
      int n_hits;
      hot_count = $urandom_range(HOT_MAX, 1);
      for (int i = 0; i < hot_count; i++) hot_pixels[i] = PIXEL_W'($urandom);
      for (int i = 0; i < 3; i++) hot_groups[i] = GROUP_W'($urandom);
      if ($urandom_range(3) == 0) hit_clock = {8'($urandom), $urandom};
      n_hits = $urandom_range(32, 4);
      repeat (n_hits) send_event_hit();
      // leave some events open so the next one piles onto them
      if ($urandom_range(99) >= 20) drain_event(15);
   endtask

   task automatic pick_config(input int seg);
      logic [DEAD_W-1:0]  dead;
      logic [COUNT_W-1:0] cut;
      logic               mode;
      case ($urandom_range(5))
         0:       dead = '0;
         1:       dead = 16'd1;
         2:       dead = DEAD_W'($urandom_range(1000, 2));
         3:       dead = DEAD_TIME_RST;
         4:       dead = DEAD_W'($urandom_range(65534, 1000));
         default: dead = '1;
      endcase
      case ($urandom_range(5))
         0:       cut = '0;
         1:       cut = 13'd1;
         2:       cut = COUNT_W'($urandom_range(8));
         3:       cut = MAX_HITS_RST;
         4:       cut = 13'd4096;
         default: cut = '1;
      endcase
      if (seg == 0) begin
         dead = '0;
         cut  = '1;
      end else if (seg == 1) begin
         dead = '1;
         cut  = '0;
      end
      mode = (seg == 2) || ($urandom_range(4) == 0);
      write_reg(CSR_EVENT_MODE, CSR_DATA_W'(mode));
      write_reg(CSR_DEAD_TIME, dead);
      write_reg(CSR_MAX_HITS, CSR_DATA_W'(cut));
   endtask

   task automatic test_dead_time_edges();
      logic [STATUS_W-1:0] st;
      send_hit(12'd0, 6'd0, 40'd0);
      send_hit(12'd0, 6'd0, RST_WINDOW - 1);
      send_hit(12'd0, 6'd0, 2 * RST_WINDOW - 1);
      send_hit(12'd0, 6'd0, RST_WINDOW);
      send_hit(12'd0, 6'd0, 40'd0);
      send_hit('1, '1, '1);
      send_hit('1, '1, '0);
      send_hit(12'hAAA, 6'h2A, 40'hAA_AAAA_AAAA);
      send_drain(st);
      send_drain(st);
      // land one hit behind the scan and one ahead of it
      send_hit(12'd1, 6'd0, 40'd1000);
      send_hit(12'd4000, 6'd7, 40'd5000);
      drain_event(0);
   endtask

   task automatic test_event_mode();
      write_reg(CSR_EVENT_MODE, 16'd1);
      write_reg(CSR_DEAD_TIME, 16'hFFFF);
      write_reg(CSR_SPARE, 16'hFFFF);
      send_hit(12'd5, 6'd1, 40'd100);
      send_hit(12'd5, 6'd1, 40'd101);
      write_reg(CSR_EVENT_MODE, 16'd0);
      send_hit(12'd5, 6'd1, 40'd102);
      // zero distance passes a zero window
      write_reg(CSR_DEAD_TIME, 16'd0);
      send_hit(12'd5, 6'd1, 40'd102);
   endtask

   task automatic test_group_cut();
      logic [STATUS_W-1:0] st;
      write_reg(CSR_MAX_HITS, 16'd1);
      send_hit(12'd10, 6'd3, 40'd200);
      send_hit(12'd11, 6'd3, 40'd300);
      send_hit(12'd12, 6'd4, 40'd400);
      drain_event(0);
      send_drain(st);
   endtask

   task automatic test_random_events();
      int seg;
      seg = 0;
      while (beats_sent < TOTAL_BEATS) begin
         pick_config(seg);
         case (seg % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 46;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 46;
            end
            default: begin
               send_idle_pct  = 30;
               recv_stall_pct = 30;
            end
         endcase
         repeat (3) run_event();
         seg++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready_q <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : response_check
      digi_response_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_responses.size() == 0) begin
            report_mismatch($sformatf("unexpected beat status %0d pixel %0d",
                                      rsp_ch.status, rsp_ch.out_pixel));
         end else begin
            want = expected_responses.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d (pixel %0d)",
                                         rsp_ch.status, want.status, want.pixel));
            if (rsp_ch.out_pixel !== want.pixel)
               report_mismatch($sformatf("out_pixel %0d, want %0d (status %0d)",
                                         rsp_ch.out_pixel, want.pixel, want.status));
            if (rsp_ch.out_time !== want.digi_time)
               report_mismatch($sformatf("out_time %0h, want %0h (pixel %0d)",
                                         rsp_ch.out_time, want.digi_time, want.pixel));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_EVENT_MODE;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_HIT;
      req_ch.pixel        = '0;
      req_ch.sensor_group = '0;
      req_ch.hit_time     = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_dead_time_edges();
      test_event_mode();
      test_group_cut();
      test_random_events();
      wait_idle();
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
sv/pdto_pkg.sv
sv/pdto_if.sv
sv/pdto_ram.sv
sv/pdto_hit_unit.sv
sv/pixel_dead_time_occupancy_filter.sv
tb/tb_top.sv
